### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked and reset-gated property checks for the hash table checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle.
`define HHT_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication into the next cycle.
`define HHT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/hht_pkg.sv
// ----------------------------------------------------------------------------
// hht_pkg
// Types, sizes and helpers shared by the hopscotch hash table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hht_pkg;

  localparam int INDEX_BITS  = 10;
  localparam int NBHD        = 32;
  localparam int KEY_BITS    = 64;
  localparam int HANDLE_BITS = 32;

  localparam int HOME_COUNT = 1 << INDEX_BITS;
  localparam int SLOT_COUNT = HOME_COUNT + NBHD;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
  localparam int OFF_W      = (NBHD > 1) ? $clog2(NBHD) : 1;

  localparam logic [NBHD-1:0] BM_ONE = NBHD'(1);

  typedef enum logic [1:0] {
    OP_GET    = 2'd0,
    OP_GET_RM = 2'd1,
    OP_PUT    = 2'd2,
    OP_REM    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    RS_MISS = 2'd0,
    RS_HIT  = 2'd1,
    RS_INS  = 2'd2,
    RS_FULL = 2'd3
  } rsp_status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_BM,
    S_SCAN,
    S_CMP,
    S_PROBE,
    S_PCHK,
    S_DISP,
    S_DCHK,
    S_MRD,
    S_MWR,
    S_MCLR,
    S_INS,
    S_IWR,
    S_RES
  } state_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] hash;
    logic [7:0]  key_length;
    logic [63:0] key_word;
    logic [15:0] value_length;
    logic [31:0] value_handle;
  } hht_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] found_length;
    logic [31:0] found_handle;
    logic [10:0] slot_index;
  } hht_rsp_t;

  typedef struct packed {
    op_e                    op;
    logic [INDEX_BITS-1:0]  home;
    logic [7:0]             klen;
    logic [KEY_BITS-1:0]    key;
    logic [15:0]            vlen;
    logic [HANDLE_BITS-1:0] hdl;
  } cmd_t;

  typedef struct packed {
    logic                   used;
    logic [KEY_BITS-1:0]    key;
    logic [7:0]             klen;
    logic [15:0]            vlen;
    logic [HANDLE_BITS-1:0] hdl;
  } slot_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_chan_t;

  function automatic logic [OFF_W-1:0] lowest(input logic [NBHD-1:0] m);
    logic [OFF_W-1:0] r;
    r = '0;
    for (int i = NBHD - 1; i >= 0; i--) begin
      if (m[i]) r = OFF_W'(i);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### design/hht_front.sv
// ----------------------------------------------------------------------------
// hht_front
// Accepts requests, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module hht_front import hht_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  output logic           full_o,
  input  wire hht_req_t  req_i,
  input  wire logic      ready_i,
  input  wire logic      pop_i,
  output cmd_chan_t      chan_o
);

  cmd_t       q_mem [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       acc, deq;
  cmd_t       cls;

  always_comb begin
    cls.op   = op_e'(req_i.cmd);
    cls.home = req_i.hash[INDEX_BITS-1:0];
    cls.klen = req_i.key_length;
    cls.key  = KEY_BITS'(req_i.key_word);
    cls.vlen = req_i.value_length;
    cls.hdl  = HANDLE_BITS'(req_i.value_handle);
  end

  assign full_o = (cnt_q == 2'd2) || !ready_i;
  assign acc    = push_i && !full_o;
  assign deq    = pop_i && (cnt_q != 2'd0);
  assign wptr_d = acc ? !wptr_q : wptr_q;
  assign rptr_d = deq ? !rptr_q : rptr_q;
  assign cnt_d  = cnt_q + {1'b0, acc} - {1'b0, deq};

  assign chan_o.valid = (cnt_q != 2'd0);
  assign chan_o.cmd   = q_mem[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) q_mem[wptr_q] <= cls;
  end

endmodule

`default_nettype wire

### design/hht_engine.sv
// ----------------------------------------------------------------------------
// hht_engine
// Table memories and the sequencer for lookup, remove, insert and displacement.
// ----------------------------------------------------------------------------
`default_nettype none

module hht_engine import hht_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cmd_chan_t chan_i,
  output logic           pop_o,
  output logic           ready_o,
  input  wire logic      res_full_i,
  output logic           res_push_o,
  output hht_rsp_t       res_o
);

  logic [NBHD-1:0] bm_mem [SLOT_COUNT];
  slot_t           sl_mem [SLOT_COUNT];

  logic            bm_we, sl_we;
  logic [SLOT_W-1:0] bm_wa, bm_ra, sl_wa, sl_ra;
  logic [NBHD-1:0] bm_wd, bm_rd_q;
  slot_t           sl_wd, sl_rd_q;

  state_e          state_q, state_d;
  cmd_t            cur_q, cur_d;
  logic [NBHD-1:0] bm_q, bm_d, scan_q, scan_d, am_q, am_d;
  logic [OFF_W-1:0] off_q, off_d, d_q, d_d, aoff_q, aoff_d;
  logic [SLOT_W-1:0] slot_q, slot_d, anc_q, anc_d, from_q, from_d;
  logic [CNT_W-1:0] fr_q, fr_d, clr_q, clr_d;
  hht_rsp_t        res_q, res_d;

  logic [OFF_W-1:0]  off_n, amoff;
  logic [SLOT_W-1:0] s_n;
  logic [CNT_W-1:0]  home_c, anchor, from_n;

  assign off_n  = lowest(scan_q);
  assign amoff  = lowest(bm_rd_q);
  assign home_c = CNT_W'(cur_q.home);
  assign s_n    = SLOT_W'(home_c + CNT_W'(off_n));
  assign anchor = fr_q - CNT_W'(d_q);
  assign from_n = anchor + CNT_W'(amoff);

  assign ready_o = (state_q != S_CLEAR);
  assign res_o   = res_q;

  always_comb begin
    state_d = state_q;
    cur_d   = cur_q;
    bm_d    = bm_q;
    scan_d  = scan_q;
    am_d    = am_q;
    off_d   = off_q;
    d_d     = d_q;
    aoff_d  = aoff_q;
    slot_d  = slot_q;
    anc_d   = anc_q;
    from_d  = from_q;
    fr_d    = fr_q;
    clr_d   = clr_q;
    res_d   = res_q;
    bm_we   = 1'b0;
    bm_wa   = '0;
    bm_wd   = '0;
    bm_ra   = '0;
    sl_we   = 1'b0;
    sl_wa   = '0;
    sl_wd   = '0;
    sl_ra   = '0;
    pop_o   = 1'b0;
    res_push_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        bm_we = 1'b1;
        bm_wa = clr_q[SLOT_W-1:0];
        sl_we = 1'b1;
        sl_wa = clr_q[SLOT_W-1:0];
        clr_d = CNT_W'(clr_q + 1'b1);
        if (clr_d == CNT_W'(SLOT_COUNT)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (chan_i.valid) begin
          pop_o   = 1'b1;
          cur_d   = chan_i.cmd;
          bm_ra   = SLOT_W'(chan_i.cmd.home);
          state_d = S_BM;
        end
      end
      S_BM: begin
        bm_d    = bm_rd_q;
        scan_d  = bm_rd_q;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (scan_q == '0) begin
          if (cur_q.op == OP_PUT) begin
            fr_d    = home_c;
            state_d = S_PROBE;
          end else begin
            res_d   = '0;
            state_d = S_RES;
          end
        end else begin
          off_d   = off_n;
          slot_d  = s_n;
          sl_ra   = s_n;
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (sl_rd_q.used && sl_rd_q.klen == cur_q.klen && sl_rd_q.key == cur_q.key) begin
          res_d            = '0;
          res_d.status     = RS_HIT;
          res_d.slot_index = 11'(slot_q);
          if (cur_q.op == OP_GET || cur_q.op == OP_GET_RM) begin
            res_d.found_length = sl_rd_q.vlen;
            res_d.found_handle = 32'(sl_rd_q.hdl);
          end
          if (cur_q.op == OP_PUT) begin
            sl_we      = 1'b1;
            sl_wa      = slot_q;
            sl_wd      = sl_rd_q;
            sl_wd.vlen = cur_q.vlen;
            sl_wd.hdl  = cur_q.hdl;
          end else if (cur_q.op != OP_GET) begin
            sl_we      = 1'b1;
            sl_wa      = slot_q;
            sl_wd      = sl_rd_q;
            sl_wd.used = 1'b0;
            bm_we      = 1'b1;
            bm_wa      = SLOT_W'(cur_q.home);
            bm_wd      = bm_q & ~(BM_ONE << off_q);
          end
          state_d = S_RES;
        end else begin
          scan_d  = scan_q & ~(BM_ONE << off_q);
          state_d = S_SCAN;
        end
      end
      S_PROBE: begin
        sl_ra   = fr_q[SLOT_W-1:0];
        state_d = S_PCHK;
      end
      S_PCHK: begin
        if (!sl_rd_q.used) begin
          if ((fr_q - home_c) < CNT_W'(NBHD)) begin
            state_d = S_INS;
          end else begin
            d_d     = OFF_W'(NBHD - 1);
            state_d = S_DISP;
          end
        end else if (CNT_W'(fr_q + 1'b1) == CNT_W'(SLOT_COUNT)) begin
          res_d        = '0;
          res_d.status = RS_FULL;
          state_d      = S_RES;
        end else begin
          fr_d    = CNT_W'(fr_q + 1'b1);
          state_d = S_PROBE;
        end
      end
      S_DISP: begin
        bm_ra   = anchor[SLOT_W-1:0];
        state_d = S_DCHK;
      end
      S_DCHK: begin
        if (bm_rd_q != '0 && from_n < fr_q) begin
          anc_d   = anchor[SLOT_W-1:0];
          am_d    = bm_rd_q;
          aoff_d  = amoff;
          from_d  = from_n[SLOT_W-1:0];
          state_d = S_MRD;
        end else if (d_q == OFF_W'(1)) begin
          res_d        = '0;
          res_d.status = RS_FULL;
          state_d      = S_RES;
        end else begin
          d_d     = d_q - OFF_W'(1);
          state_d = S_DISP;
        end
      end
      S_MRD: begin
        sl_ra   = from_q;
        state_d = S_MWR;
      end
      S_MWR: begin
        sl_we      = 1'b1;
        sl_wa      = fr_q[SLOT_W-1:0];
        sl_wd      = sl_rd_q;
        sl_wd.used = 1'b1;
        bm_we      = 1'b1;
        bm_wa      = anc_q;
        bm_wd      = (am_q | (BM_ONE << d_q)) & ~(BM_ONE << aoff_q);
        state_d    = S_MCLR;
      end
      S_MCLR: begin
        sl_we = 1'b1;
        sl_wa = from_q;
        fr_d  = CNT_W'(from_q);
        if ((CNT_W'(from_q) - home_c) < CNT_W'(NBHD)) begin
          state_d = S_INS;
        end else begin
          d_d     = OFF_W'(NBHD - 1);
          state_d = S_DISP;
        end
      end
      S_INS: begin
        sl_we      = 1'b1;
        sl_wa      = fr_q[SLOT_W-1:0];
        sl_wd.used = 1'b1;
        sl_wd.key  = cur_q.key;
        sl_wd.klen = cur_q.klen;
        sl_wd.vlen = cur_q.vlen;
        sl_wd.hdl  = cur_q.hdl;
        bm_ra      = SLOT_W'(cur_q.home);
        state_d    = S_IWR;
      end
      S_IWR: begin
        bm_we            = 1'b1;
        bm_wa            = SLOT_W'(cur_q.home);
        bm_wd            = bm_rd_q | (BM_ONE << OFF_W'(fr_q - home_c));
        res_d            = '0;
        res_d.status     = RS_INS;
        res_d.slot_index = 11'(fr_q);
        state_d          = S_RES;
      end
      S_RES: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    bm_q   <= bm_d;
    scan_q <= scan_d;
    am_q   <= am_d;
    off_q  <= off_d;
    d_q    <= d_d;
    aoff_q <= aoff_d;
    slot_q <= slot_d;
    anc_q  <= anc_d;
    from_q <= from_d;
    fr_q   <= fr_d;
    res_q  <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (bm_we) bm_mem[bm_wa] <= bm_wd;
    bm_rd_q <= bm_mem[bm_ra];
  end

  always_ff @(posedge clk_i) begin
    if (sl_we) sl_mem[sl_wa] <= sl_wd;
    sl_rd_q <= sl_mem[sl_ra];
  end

endmodule

`default_nettype wire

### design/hht_rsp_q.sv
// ----------------------------------------------------------------------------
// hht_rsp_q
// Two-entry result queue between the sequencer and the result port.
// ----------------------------------------------------------------------------
`default_nettype none

module hht_rsp_q import hht_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire hht_rsp_t rsp_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output logic          empty_o,
  output hht_rsp_t      rsp_o
);

  hht_rsp_t   q_mem [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       acc, deq;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign acc     = push_i && !full_o;
  assign deq     = pop_i && !empty_o;
  assign rsp_o   = q_mem[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (acc) wptr_q <= !wptr_q;
      if (deq) rptr_q <= !rptr_q;
      cnt_q <= cnt_q + {1'b0, acc} - {1'b0, deq};
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) q_mem[wptr_q] <= rsp_i;
  end

endmodule

`default_nettype wire

### design/hopscotch_hash_table.sv
// A get or remove reads the home bitmap and compares the neighborhood entries in turn;
// a put that finds no match also probes for a free slot, checks displacement candidates,
// moves entries to bring the free slot into the neighborhood and then inserts the entry.
// The sequencer handles one request at a time, paced by table memory reads with
// registered data; it stalls while the result queue is full.
// Reset: a clearing pass zeroes bitmaps and used flags; full stays high until it ends.
// ----------------------------------------------------------------------------
// hopscotch_hash_table
// Hopscotch hash table with a request queue, sequencer and result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module hopscotch_hash_table import hht_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push,
  output logic          full,
  input  wire hht_req_t req_i,
  input  wire logic     pop,
  output logic          empty,
  output hht_rsp_t      rsp_o
);

  cmd_chan_t chan;
  logic      eng_pop, eng_ready, res_full, res_push;
  hht_rsp_t  res;

  hht_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .req_i   (req_i),
    .ready_i (eng_ready),
    .pop_i   (eng_pop),
    .chan_o  (chan)
  );

  hht_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .chan_i     (chan),
    .pop_o      (eng_pop),
    .ready_o    (eng_ready),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res)
  );

  hht_rsp_q u_rsp_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .rsp_i   (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .empty_o (empty),
    .rsp_o   (rsp_o)
  );

endmodule

`default_nettype wire

### design/hht_checker.sv
// ----------------------------------------------------------------------------
// hht_checker
// Port-level checks on result encoding and result queue behavior.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module hht_checker import hht_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     pop,
  input wire logic     empty,
  input wire hht_rsp_t rsp_o
);

  `HHT_ASSERT_IMPL(a_no_found_unless_hit, !empty && rsp_o.status != RS_HIT, rsp_o.found_length == '0 && rsp_o.found_handle == '0, "found fields set without a hit")
  `HHT_ASSERT_IMPL(a_zero_slot_on_fail, !empty && (rsp_o.status == RS_MISS || rsp_o.status == RS_FULL), rsp_o.slot_index == '0, "slot index set on miss or full")
  `HHT_ASSERT_IMPL(a_slot_range, !empty, rsp_o.slot_index < SLOT_COUNT, "slot index out of table")
  `HHT_ASSERT_NEXT(a_rsp_hold, !empty && !pop, !empty && $stable(rsp_o), "waiting result changed")

endmodule

bind hopscotch_hash_table hht_checker u_hht_checker (.*);

`default_nettype wire
